[design/dqaqm_pkg.sv]
// Package for the dual-queue coupled AQM decision core.
// Holds fixed-point widths, action and outcome codes, register indexes and the
// configuration struct. It depends on nothing else.
package dqaqm_pkg;

	// Fixed-point formats.
	localparam int PROB_FRAC_BITS = 24;
	localparam int SOJOURN_BITS   = 24;
	localparam int PROB_W         = PROB_FRAC_BITS + 1;
	localparam int SOJ_W          = (SOJOURN_BITS < 24) ? SOJOURN_BITS : 24;
	localparam int OUT_PROB_W     = 25;

	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

	// Input field and configuration port widths.
	localparam int FIELD_W   = 24;
	localparam int CFG_IDX_W = 3;

	// Action codes.
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_L4S_DEQ = 2'd1;
	localparam logic [1:0] ACT_CLS_ENQ = 2'd2;

	// Outcome codes.
	localparam logic [1:0] OUT_PASS    = 2'd0;
	localparam logic [1:0] OUT_SET_CE  = 2'd1;
	localparam logic [1:0] OUT_CE_HIT  = 2'd2;
	localparam logic [1:0] OUT_DROP    = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_L4S_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLS_TARGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd5;

	typedef struct packed {
		logic [23:0] l4s_target_us;
		logic [23:0] classic_target_us;
		logic [15:0] coupling_factor;
		logic [23:0] alpha_gain;
		logic [23:0] beta_gain;
		logic [15:0] floor_bytes;
	} cfg_t;

endpackage

[design/dqaqm_pi_update.sv]
// PI integrator step of the coupled AQM: new base probability from a tick.
// Depends on dqaqm_pkg.
module dqaqm_pi_update (
	input  dqaqm_pkg::cfg_t                     cfg,
	input  logic [dqaqm_pkg::PROB_W-1:0]        base_prob,
	input  logic [dqaqm_pkg::SOJ_W-1:0]         prev_sojourn,
	input  logic [dqaqm_pkg::SOJ_W-1:0]         sojourn,
	output logic [dqaqm_pkg::PROB_W-1:0]        next_prob
);
	import dqaqm_pkg::*;

	localparam int PROD_W = 50;
	localparam int BIG_W  = (PROB_W + 17 > PROD_W + 1) ? PROB_W + 17 : PROD_W + 1;
	localparam int ACC_W  = BIG_W + 1;
	localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'(PROB_ONE) <<< 16;

	logic signed [24:0]        err;
	logic signed [24:0]        diff;
	logic signed [24:0]        alpha_s;
	logic signed [24:0]        beta_s;
	logic signed [PROD_W-1:0]  p_alpha;
	logic signed [PROD_W-1:0]  p_beta;
	logic signed [ACC_W-1:0]   acc;
	logic [PROB_W+15:0]        clamped;
	logic [PROB_W+15:0]        rounded;

	always_comb begin
		err     = $signed({1'b0, 24'(sojourn)}) - $signed({1'b0, cfg.classic_target_us});
		diff    = $signed({1'b0, 24'(sojourn)}) - $signed({1'b0, 24'(prev_sojourn)});
		alpha_s = $signed({1'b0, cfg.alpha_gain});
		beta_s  = $signed({1'b0, cfg.beta_gain});
		p_alpha = alpha_s * err;
		p_beta  = beta_s * diff;
		acc     = $signed({{(ACC_W-PROB_W-16){1'b0}}, base_prob, 16'b0})
		        + ACC_W'(p_alpha) + ACC_W'(p_beta);
		// Clamp to [0, one] in Q.16 before rounding back to probability LSBs.
		if (acc < 0) begin
			clamped = '0;
		end else if (acc > ACC_TOP) begin
			clamped = (PROB_W+16)'(ACC_TOP);
		end else begin
			clamped = (PROB_W+16)'(acc);
		end
		rounded   = clamped + (PROB_W+16)'(32'h8000);
		next_prob = rounded[PROB_W+15:16];
	end

endmodule

[design/dqaqm_decide.sv]
// Mark and drop decision for L4S dequeues and classic enqueues.
// Depends on dqaqm_pkg.
module dqaqm_decide (
	input  dqaqm_pkg::cfg_t                      cfg,
	input  logic [1:0]                           action,
	input  logic [dqaqm_pkg::SOJ_W-1:0]          sojourn,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        total_queue_bytes,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        random_draw,
	input  logic                                 already_ce,
	input  logic [dqaqm_pkg::PROB_W-1:0]         base_prob,
	output logic [1:0]                           outcome,
	output logic [dqaqm_pkg::PROB_W-1:0]         applied_prob
);
	import dqaqm_pkg::*;

	logic [PROB_W+15:0]               kp;
	logic [PROB_W+7:0]                kp_sh;
	logic [PROB_W-1:0]                coupled;
	logic [2*PROB_W-1:0]              sq;
	logic [PROB_W-1:0]                squared;
	logic [PROB_FRAC_BITS+23:0]       draw_ext;
	logic [PROB_FRAC_BITS-1:0]        draw_al;
	logic                             above_floor;
	logic                             fire;

	always_comb begin
		kp      = (PROB_W+16)'(cfg.coupling_factor) * (PROB_W+16)'(base_prob);
		kp_sh   = kp[PROB_W+15:8];
		coupled = (kp_sh > (PROB_W+8)'(PROB_ONE)) ? PROB_ONE : kp_sh[PROB_W-1:0];

		sq      = (2*PROB_W)'(base_prob) * (2*PROB_W)'(base_prob);
		squared = (base_prob >= PROB_ONE) ? PROB_ONE
		        : sq[PROB_FRAC_BITS+PROB_W-1:PROB_FRAC_BITS];

		// Align the Q0.24 draw to the probability format.
		draw_ext = {random_draw, {PROB_FRAC_BITS{1'b0}}};
		draw_al  = draw_ext[PROB_FRAC_BITS+23:24];

		above_floor = total_queue_bytes >= {8'b0, cfg.floor_bytes};

		case (action)
			ACT_L4S_DEQ: begin
				if (24'(sojourn) >= cfg.l4s_target_us) begin
					applied_prob = PROB_ONE;
				end else if (!above_floor) begin
					applied_prob = '0;
				end else begin
					applied_prob = coupled;
				end
			end
			ACT_CLS_ENQ: begin
				applied_prob = above_floor ? squared : '0;
			end
			default: begin
				applied_prob = '0;
			end
		endcase

		fire = (applied_prob != '0) && ({1'b0, draw_al} < applied_prob);

		case (action)
			ACT_L4S_DEQ: outcome = !fire ? OUT_PASS : (already_ce ? OUT_CE_HIT : OUT_SET_CE);
			ACT_CLS_ENQ: outcome = fire ? OUT_DROP : OUT_PASS;
			default:     outcome = OUT_PASS;
		endcase
	end

endmodule

[design/dual_queue_coupled_aqm.sv]
// Dual-queue coupled AQM decision core: top level with input, state and result registers.
// A result word is registered from the input register, one per cycle unless stalled.
// The rate is set by the single pass through the PI step or the mark/drop multiplies.
// Reset clears base probability, previous sojourn and both valid flags, and loads
// the register defaults. Depends on dqaqm_pkg, dqaqm_pi_update and dqaqm_decide.
module dual_queue_coupled_aqm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [dqaqm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        cfg_data,
	// Item channel.
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [1:0]                           action,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        sojourn_us,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        total_queue_bytes,
	input  logic [dqaqm_pkg::FIELD_W-1:0]        random_draw,
	input  logic                                 already_ce,
	// Result channel.
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [1:0]                           outcome,
	output logic [dqaqm_pkg::OUT_PROB_W-1:0]     applied_prob,
	output logic [dqaqm_pkg::OUT_PROB_W-1:0]     base_prob_now
);
	import dqaqm_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	// Controller state.
	logic [PROB_W-1:0]  base_prob_q;
	logic [SOJ_W-1:0]   prev_sojourn_q;

	// Input register: the item word waiting for its single compute pass.
	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [SOJ_W-1:0]   sojourn_s1;
	logic [FIELD_W-1:0] total_s1;
	logic [FIELD_W-1:0] draw_s1;
	logic               ce_s1;

	// Result register.
	logic                  result_valid_q;
	logic [1:0]            outcome_q;
	logic [PROB_W-1:0]     applied_q;
	logic [PROB_W-1:0]     base_now_q;

	logic                  advance;
	logic                  item_accept;
	logic                  commit;
	logic                  tick_commit;
	logic [PROB_W-1:0]     next_prob;
	logic [PROB_W-1:0]     base_after;
	logic [1:0]            outcome_c;
	logic [PROB_W-1:0]     applied_c;

	// The input register moves on whenever the result register is empty or being
	// taken. An empty input register also takes an item word while a finished
	// result still waits.
	assign advance     = !result_valid_q || !result_stall;
	assign item_stall  = valid_s1 && !advance;
	assign item_accept = item_valid && !item_stall;
	assign commit      = valid_s1 && advance;
	assign tick_commit = commit && (action_s1 == ACT_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.l4s_target_us     <= 24'd1000;
			cfg_q.classic_target_us <= 24'd15000;
			cfg_q.coupling_factor   <= 16'd512;
			cfg_q.alpha_gain        <= 24'd175922;
			cfg_q.beta_gain         <= 24'd3518437;
			cfg_q.floor_bytes       <= 16'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_L4S_TARGET: cfg_q.l4s_target_us     <= cfg_data;
				REG_CLS_TARGET: cfg_q.classic_target_us <= cfg_data;
				REG_COUPLING:   cfg_q.coupling_factor   <= cfg_data[15:0];
				REG_ALPHA:      cfg_q.alpha_gain        <= cfg_data;
				REG_BETA:       cfg_q.beta_gain         <= cfg_data;
				REG_FLOOR:      cfg_q.floor_bytes       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Input register control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			action_s1  <= action;
			sojourn_s1 <= sojourn_us[SOJ_W-1:0];
			total_s1   <= total_queue_bytes;
			draw_s1    <= random_draw;
			ce_s1      <= already_ce;
		end
	end

	dqaqm_pi_update u_pi (
		.cfg          (cfg_q),
		.base_prob    (base_prob_q),
		.prev_sojourn (prev_sojourn_q),
		.sojourn      (sojourn_s1),
		.next_prob    (next_prob)
	);

	dqaqm_decide u_decide (
		.cfg               (cfg_q),
		.action            (action_s1),
		.sojourn           (sojourn_s1),
		.total_queue_bytes (total_s1),
		.random_draw       (draw_s1),
		.already_ce        (ce_s1),
		.base_prob         (base_prob_q),
		.outcome           (outcome_c),
		.applied_prob      (applied_c)
	);

	// Only a tick changes p'; every other word reports the current value.
	assign base_after = (action_s1 == ACT_TICK) ? next_prob : base_prob_q;

	// State is committed in the same edge that the result word is registered,
	// so the next word in the input register already sees the new p'.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_prob_q    <= '0;
			prev_sojourn_q <= '0;
		end else if (tick_commit) begin
			base_prob_q    <= next_prob;
			prev_sojourn_q <= sojourn_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			outcome_q  <= outcome_c;
			applied_q  <= applied_c;
			base_now_q <= base_after;
		end
	end

	assign result_valid  = result_valid_q;
	assign outcome       = outcome_q;
	assign applied_prob  = OUT_PROB_W'(applied_q);
	assign base_prob_now = OUT_PROB_W'(base_now_q);

	// The base probability never leaves [0, one].
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		base_prob_q <= PROB_ONE)
		else $error("base probability above one");

	// The base probability changes only when a tick word is committed.
	a_prob_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(base_prob_q) |-> $past(tick_commit))
		else $error("base probability changed without a tick");

	// A drop or a mark needs a nonzero applied probability.
	a_fire_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (outcome_q != OUT_PASS) |-> (applied_q != '0))
		else $error("event fired at zero probability");

	// The input register is never overwritten while it is held.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1) && $stable(sojourn_s1))
		else $error("held item word lost");

endmodule
